/* rtl/core/vtp_pkg.sv */
// Package for the vertex transform core: widths, fixed-point constants, stage types.
package vtp_pkg;

  localparam int DataW    = 32;
  localparam int FracBits = 16;
  localparam int CfgW     = 64;
  localparam int NumRegs  = 8;
  localparam int IdxW     = 3;
  localparam int ProdW    = 2 * DataW;
  localparam int SumW     = ProdW + 2;
  localparam int DivNumW  = DataW + FracBits;   // magnitude of x << FracBits
  localparam int QuotW    = DivNumW;

  localparam logic [DataW-1:0] FxOne = DataW'(1) << FracBits;

  localparam logic signed [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic {
    OP_XFORM   = 1'b0,
    OP_PROJECT = 1'b1
  } op_t;

  typedef logic signed [DataW-1:0] fx_t;

  typedef struct packed {
    fx_t [3:0] coef;
  } mrow_t;

  // Work on its way through the divide pipeline.
  typedef struct packed {
    logic                   do_div;
    logic                   w_zero;
    logic                   sat;
    fx_t                    w;
    logic [2:0]             neg;
    logic [2:0][DivNumW-1:0] rem;
    logic [2:0][QuotW-1:0]   quo;
    logic [DataW-1:0]       den;
    fx_t  [2:0]             raw;
  } div_word_t;

  // Saturate an exact row sum after the fraction shift.
  function automatic fx_t sat_shift(input logic signed [SumW-1:0] s, output logic ovf);
    logic signed [SumW-1:0] sh;
    sh = s >>> FracBits;
    if (sh > SumW'(SMax)) begin
      ovf = 1'b1;
      return SMax;
    end else if (sh < SumW'(SMin)) begin
      ovf = 1'b1;
      return SMin;
    end
    ovf = 1'b0;
    return sh[DataW-1:0];
  endfunction

endpackage

/* rtl/core/vtp_mac.sv */
// Matrix-vector stage: multiply, add tree, shift and clamp over three registered stages.
module vtp_mac (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic                in_op,
  input  vtp_pkg::fx_t [3:0]  vec,
  input  vtp_pkg::mrow_t [3:0] mat,
  output logic                out_valid,
  output logic                out_op,
  output vtp_pkg::fx_t [3:0]  res,
  output logic                out_sat
);
  import vtp_pkg::*;

  logic [2:0] vld;
  logic [1:0] opq;
  logic signed [ProdW-1:0] prod [4][4];
  logic signed [SumW-1:0]  half [4][2];
  logic signed [SumW-1:0]  sum_c [4];
  fx_t  [3:0] clamp_c;
  logic [3:0] ovf_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opq <= {opq[0], in_op};
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= ProdW'(mat[r].coef[c]) * ProdW'(vec[c]);
        end
        half[r][0] <= SumW'(prod[r][0]) + SumW'(prod[r][1]);
        half[r][1] <= SumW'(prod[r][2]) + SumW'(prod[r][3]);
      end
      out_op  <= opq[1];
      res     <= clamp_c;
      out_sat <= |ovf_c;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_c[r]   = half[r][0] + half[r][1];
      clamp_c[r] = sat_shift(sum_c[r], ovf_c[r]);
    end
  end

  assign out_valid = vld[2];

  // The pipe never fills with a valid word out of reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("mac valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("mac moved while stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst) adv |=> vld[0] == $past(in_valid))
    else $error("mac lost a word");
endmodule

/* rtl/core/vtp_div.sv */
// Pipelined restoring divider: three lanes share one denominator, one quotient bit a stage.
module vtp_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic               in_op,
  input  vtp_pkg::fx_t [3:0] in_res,
  input  logic               in_sat,
  output logic               out_valid,
  output vtp_pkg::fx_t [3:0] res,
  output logic               w_zero,
  output logic               saturated
);
  import vtp_pkg::*;

  localparam int Steps = QuotW;

  logic [Steps:0] vld;
  div_word_t      pipe [Steps+1];
  div_word_t      head;
  div_word_t      stepw [Steps];
  fx_t  [3:0]     fin_res;
  logic           fin_sat;

  // Load: magnitudes, signs, zero-w check.
  always_comb begin
    logic [DataW-1:0] wmag;
    logic [DataW-1:0] amag;
    head = '0;
    wmag = in_res[3][DataW-1] ? DataW'(-in_res[3]) : in_res[3];
    head.w      = in_res[3];
    head.sat    = in_sat;
    head.w_zero = (in_op == OP_PROJECT) && (in_res[3] == '0);
    head.do_div = (in_op == OP_PROJECT) && (in_res[3] != '0);
    head.den    = wmag;
    for (int i = 0; i < 3; i++) begin
      amag = in_res[i][DataW-1] ? DataW'(-in_res[i]) : in_res[i];
      head.raw[i] = in_res[i];
      head.neg[i] = in_res[i][DataW-1] ^ in_res[3][DataW-1];
      head.rem[i] = '0;
      head.quo[i] = {amag, {FracBits{1'b0}}};
    end
  end

  // One shift-subtract per stage; quo holds remaining dividend bits then quotient.
  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      logic [DivNumW:0] trial;
      stepw[s] = pipe[s];
      for (int i = 0; i < 3; i++) begin
        trial = {pipe[s].rem[i], pipe[s].quo[i][QuotW-1]} - (DivNumW+1)'(pipe[s].den);
        if (!trial[DivNumW]) begin
          stepw[s].rem[i] = trial[DivNumW-1:0];
          stepw[s].quo[i] = {pipe[s].quo[i][QuotW-2:0], 1'b1};
        end else begin
          stepw[s].rem[i] = {pipe[s].rem[i][DivNumW-2:0], pipe[s].quo[i][QuotW-1]};
          stepw[s].quo[i] = {pipe[s].quo[i][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Steps-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= head;
      for (int s = 0; s < Steps; s++) begin
        pipe[s+1] <= stepw[s];
      end
    end
  end

  // Sign and clamp of the quotients; raw values pass through when no divide is done.
  always_comb begin
    div_word_t t;
    t = pipe[Steps];
    fin_sat = t.sat;
    for (int i = 0; i < 3; i++) begin
      if (!t.do_div) begin
        fin_res[i] = t.raw[i];
      end else if (t.neg[i]) begin
        if (t.quo[i] > (QuotW'(1) << (DataW-1))) begin
          fin_res[i] = SMin;
          fin_sat = 1'b1;
        end else begin
          fin_res[i] = DataW'(-t.quo[i]);
        end
      end else if (t.quo[i] > QuotW'(SMax)) begin
        fin_res[i] = SMax;
        fin_sat = 1'b1;
      end else begin
        fin_res[i] = t.quo[i][DataW-1:0];
      end
    end
    fin_res[3] = t.w;
  end

  assign out_valid = vld[Steps];
  assign res       = fin_res;
  assign w_zero    = pipe[Steps].w_zero;
  assign saturated = fin_sat;

  a_wz_nodiv: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> !pipe[Steps].do_div)
    else $error("divide with zero w");
  a_wz_w: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> res[3] == '0)
    else $error("w_zero with nonzero w");
  a_stall: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("div moved while stalled");
endmodule

/* rtl/core/vertex_transform_project_core.sv */
// Top level of the vertex transform and perspective divide core.
// One vertex word is accepted per cycle while in_ready is high, and passes through
// three multiply/add stages, a divider load register plus 48 divider stages (one
// quotient bit each over 32+16 bits) and an output register, 53 register stages in
// all, with op 0 taking the same path. The whole pipe advances whenever the output
// register is empty or taken, so throughput is one vertex per clock. The matrix
// must be written through cfg only while idle; the block does not enforce this.
// Reset loads the identity.
module vertex_transform_project_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic signed [31:0]   in_x,
  input  logic signed [31:0]   in_y,
  input  logic signed [31:0]   in_z,
  input  logic signed [31:0]   in_w,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic signed [31:0]   out_w,
  output logic                 w_zero,
  output logic                 saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import vtp_pkg::*;

  logic [CfgW-1:0] mreg [NumRegs];
  mrow_t [3:0] mat;
  fx_t [3:0] vec;
  logic adv;
  logic m_valid, m_op, m_sat;
  fx_t [3:0] m_res;
  logic d_valid, d_wz, d_sat;
  fx_t [3:0] d_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= CfgW'(FxOne);
      mreg[1] <= '0;
      mreg[2] <= {FxOne, {DataW{1'b0}}};
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= CfgW'(FxOne);
      mreg[6] <= '0;
      mreg[7] <= {FxOne, {DataW{1'b0}}};
    end else if (cfg_valid) begin
      mreg[cfg_index[IdxW-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r].coef[0] = mreg[2*r][DataW-1:0];
      mat[r].coef[1] = mreg[2*r][CfgW-1:DataW];
      mat[r].coef[2] = mreg[2*r+1][DataW-1:0];
      mat[r].coef[3] = mreg[2*r+1][CfgW-1:DataW];
    end
  end

  assign vec      = {in_w, in_z, in_y, in_x};
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  vtp_mac u_mac (
    .clk, .rst, .adv,
    .in_valid (in_valid),
    .in_op    (op),
    .vec      (vec),
    .mat      (mat),
    .out_valid(m_valid),
    .out_op   (m_op),
    .res      (m_res),
    .out_sat  (m_sat)
  );

  vtp_div u_div (
    .clk, .rst, .adv,
    .in_valid (m_valid),
    .in_op    (m_op),
    .in_res   (m_res),
    .in_sat   (m_sat),
    .out_valid(d_valid),
    .res      (d_res),
    .w_zero   (d_wz),
    .saturated(d_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x     <= d_res[0];
      out_y     <= d_res[1];
      out_z     <= d_res[2];
      out_w     <= d_res[3];
      w_zero    <= d_wz;
      saturated <= d_sat;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_w))
    else $error("word dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");
  a_wz_op: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> out_w == '0)
    else $error("w_zero with nonzero w");
endmodule

/* dv/vtp_checker.sv */
// Checker for the vertex transform core: predicts each result word and compares it.
`timescale 1ns / 1ps
module vtp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic signed [31:0] out_w,
  input  logic               w_zero,
  input  logic               saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import vtp_pkg::*;

  typedef struct packed {
    logic [31:0] x, y, z, w;
    logic        wz, sat;
  } vres_t;

  logic [63:0] matrix [NumRegs];
  vres_t       expected_q [$];

  // row sum of four exact products, floor shift, clamp
  function automatic logic signed [31:0] row_sum(input logic [63:0] r01, input logic [63:0] r23,
                                                input logic signed [31:0] v [4],
                                                inout logic sat);
    logic signed [31:0]  c [4];
    logic signed [127:0] acc;
    logic signed [127:0] sh;
    c[0] = r01[31:0];  c[1] = r01[63:32];
    c[2] = r23[31:0];  c[3] = r23[63:32];
    acc = 0;
    for (int i = 0; i < 4; i++) acc += 128'(c[i]) * 128'(v[i]);
    sh = acc >>> FracBits;
    if (sh > 128'sd2147483647) begin
      sat = 1'b1;
      return SMax;
    end
    if (sh < -128'sd2147483648) begin
      sat = 1'b1;
      return SMin;
    end
    return sh[31:0];
  endfunction

  // (a << frac) / b truncated toward zero, clamped
  function automatic logic signed [31:0] fx_quot(input logic signed [31:0] a,
                                                input logic signed [31:0] b, inout logic sat);
    logic        neg;
    logic [63:0] ua, ub, q;
    neg = (a < 0) != (b < 0);
    ua = (a < 0 ? 64'(-64'(a)) : 64'(a)) << FracBits;
    ub = b < 0 ? 64'(-64'(b)) : 64'(b);
    q = ua / ub;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        q = 64'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      q = 64'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic vres_t transform_vertex(input logic opb, input logic signed [31:0] v [4]);
    vres_t              e;
    logic               sat;
    logic signed [31:0] r [4];
    sat = 1'b0;
    for (int i = 0; i < 4; i++) r[i] = row_sum(matrix[2*i], matrix[2*i+1], v, sat);
    e.wz = 1'b0;
    if (op_t'(opb) == OP_PROJECT) begin
      if (r[3] == 0) e.wz = 1'b1;
      else for (int i = 0; i < 3; i++) r[i] = fx_quot(r[i], r[3], sat);
    end
    e.x = r[0]; e.y = r[1]; e.z = r[2]; e.w = r[3];
    e.sat = sat;
    return e;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    logic signed [31:0] v [4];
    vres_t              got, e;
    if (rst) begin
      matrix[0] <= 64'(FxOne);          matrix[1] <= '0;
      matrix[2] <= 64'(FxOne) << 32;    matrix[3] <= '0;
      matrix[4] <= '0;                  matrix[5] <= 64'(FxOne);
      matrix[6] <= '0;                  matrix[7] <= 64'(FxOne) << 32;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) matrix[cfg_index] <= cfg_data;
      if (in_valid && in_ready) begin
        v[0] = in_x; v[1] = in_y; v[2] = in_z; v[3] = in_w;
        expected_q.push_back(transform_vertex(op, v));
      end
      if (out_valid && out_ready) begin
        got = '{out_x, out_y, out_z, out_w, w_zero, saturated};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            if (fail_count < 10)
              $display({"mismatch: exp x=%h y=%h z=%h w=%h wz=%b sat=%b",
                        " / got x=%h y=%h z=%h w=%h wz=%b sat=%b"},
                       e.x, e.y, e.z, e.w, e.wz, e.sat,
                       got.x, got.y, got.z, got.w, got.wz, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* dv/testbench.sv */
// Testbench top: stimulus, matrix phases and verdict for the vertex transform core.
`timescale 1ns / 1ps
module testbench;
  import vtp_pkg::*;

  localparam int Latency = 53;
  localparam int MaxCycles = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic op = 1'b0;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic w_zero, saturated;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  int rx_gap = 0;
  bit hold_off = 1'b0;

  always #10 clk = ~clk;

  vertex_transform_project_core u_dut (.*);
  vtp_checker u_chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 3) return $urandom_range(20, 80);
    if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
    return 0;
  endfunction

  // interesting 32-bit values
  function automatic logic [31:0] pick_val(input int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(FxOne);
      4: return -32'(FxOne);
      5: return 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_val();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return pick_val($urandom_range(0, 4));
    if (r < 7) return pick_val(5);
    return $urandom;
  endfunction

  task automatic send_vertex(input logic o, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
    in_valid <= 1'b1;
    op <= o; in_x <= x; in_y <= y; in_z <= z; in_w <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!($urandom_range(0, 3) == 0)) return;
    begin
      int g;
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // valid stays up across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] coef(input int kind);
    case (kind)
      0: return 32'(FxOne);
      1: return 32'h0;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_matrix(input int kind);
    for (int i = 0; i < NumRegs; i++)
      write_reg(3'(i), {coef(kind == 9 ? $urandom_range(0, 5) : kind),
                        coef(kind == 9 ? $urandom_range(0, 5) : kind)});
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls of random length, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      rx_gap <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset identity matrix, extremes and both ops
    send_vertex(OP_XFORM,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'(FxOne));
    send_vertex(OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'(FxOne), 32'(FxOne));
    send_vertex(OP_PROJECT, 32'(FxOne), 32'(FxOne), 32'(FxOne), 32'h0);      // zero w
    send_vertex(OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1);     // divide clamps
    send_vertex(OP_PROJECT, 32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFD, 32'hFFFE_0000);
    send_vertex(OP_XFORM,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    // all-max matrix: transform overflow
    load_matrix(2);
    send_vertex(OP_XFORM,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(OP_PROJECT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(OP_PROJECT, 32'(FxOne), 32'h0, 32'h0, 32'h0);
    drain();
    load_matrix(3);
    send_vertex(OP_XFORM,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(OP_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
    drain();
    load_matrix(1);
    send_vertex(OP_PROJECT, $urandom, $urandom, $urandom, $urandom);
    send_vertex(OP_XFORM,   $urandom, $urandom, $urandom, $urandom);
    drain();

    // random phases over several matrices
    for (int ph = 0; ph < 7; ph++) begin
      load_matrix(ph == 0 ? 0 : (ph == 6 ? 5 : 9));
      if (ph == 2) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 200; n++)
        send_vertex(1'($urandom_range(0, 1)), rnd_val(), rnd_val(), rnd_val(), rnd_val());
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
